FILE: hw/rtl/pfba_pkg.sv
// Package: shared types and constants of the page frame bitmap allocator.
`default_nettype none
package pfba_pkg;

  localparam int FRAME_W      = 12;
  localparam int WORD_W       = 32;
  localparam int BITMAP_DEPTH = 128;
  localparam int WORD_IDX_W   = 7;
  localparam int BIT_IDX_W    = 5;
  localparam int CNT_W        = 8;

  localparam logic [WORD_W-1:0] FULL_WORD     = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0]  WORDS_RST_VAL = 8'd128;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FRAME_W-1:0] page_frame;
    logic               kernel_only;
    logic               writable;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] entry_frame;
    logic               entry_present;
    logic               entry_rw;
    logic               entry_user;
    logic               entry_changed;
    logic               no_free_frame;
    logic               frame_in_use;
  } res_t;

  typedef struct packed {
    logic accept;
    logic init;
    logic lookup;
    logic update;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic word_needed;
    logic found;
    logic scan_end;
  } ctrl_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pfba_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pfba_ctrl.sv
// Controller state machine of the page frame bitmap allocator.
`default_nettype none
module pfba_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire pfba_pkg::ctrl_status_t status,
  output pfba_pkg::ctrl_cmd_t        cmd,
  output logic                       busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_UPDATE = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.init = 1'b1;
        if (status.scan_needed) begin
          state_next = S_SCAN;
        end else if (status.word_needed) begin
          cmd.lookup = 1'b1;
          state_next = S_UPDATE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.found || status.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

FILE: hw/rtl/pfba_datapath.sv
// Datapath: bitmap store, word scan, bit update and result register.
`default_nettype none
module pfba_datapath #(
  parameter int STORE_WORDS = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pfba_pkg::ctrl_cmd_t               cmd,
  output pfba_pkg::ctrl_status_t                 status,
  input  wire pfba_pkg::req_t                    request,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pfba_pkg::CNT_W-1:0]        cfg_data,
  output logic                                   done,
  output pfba_pkg::res_t                         result
);

  localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [pfba_pkg::CNT_W-1:0] STORE_CNT = pfba_pkg::CNT_W'(STORE_WORDS);

  pfba_pkg::req_t                          req_q;
  logic [pfba_pkg::CNT_W-1:0]              words_in_use;
  logic [pfba_pkg::CNT_W-1:0]              limit;
  logic [pfba_pkg::CNT_W-1:0]              scan_idx;
  logic                                    chk_valid;
  logic [pfba_pkg::WORD_IDX_W-1:0]         chk_idx;
  logic                                    rd_mask;
  logic [STORE_WORDS-1:0]                  valid;
  logic                                    found_q;
  logic [pfba_pkg::FRAME_W-1:0]            found_frame;
  logic                                    inuse_q;
  pfba_pkg::res_t                          res_next;

  logic                                    issue;
  logic                                    stored;
  logic [ADDR_W-1:0]                       word_addr;
  logic                                    rd_en;
  logic [ADDR_W-1:0]                       rd_addr;
  logic [pfba_pkg::WORD_W-1:0]             rd_data;
  logic [pfba_pkg::WORD_W-1:0]             word;
  logic                                    wr_en;
  logic [ADDR_W-1:0]                       wr_addr;
  logic [pfba_pkg::WORD_W-1:0]             wr_data;
  logic [pfba_pkg::BIT_IDX_W-1:0]          free_pos;
  logic [pfba_pkg::BIT_IDX_W-1:0]          bit_pos;
  logic                                    word_full;

  function automatic logic [pfba_pkg::BIT_IDX_W-1:0] lowest_zero(
    input logic [pfba_pkg::WORD_W-1:0] w
  );
    logic [pfba_pkg::BIT_IDX_W-1:0] pos;
    pos = '0;
    for (int i = pfba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = pfba_pkg::BIT_IDX_W'(i);
      end
    end
    return pos;
  endfunction

  assign cfg_ready = 1'b1;
  assign limit     = (words_in_use > STORE_CNT) ? STORE_CNT : words_in_use;
  assign stored    = ({1'b0, req_q.page_frame[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_IDX_W]}
                      < STORE_CNT);
  assign word_addr = req_q.page_frame[pfba_pkg::BIT_IDX_W +: ADDR_W];
  assign bit_pos   = req_q.page_frame[pfba_pkg::BIT_IDX_W-1:0];
  assign issue     = (scan_idx < limit);

  assign rd_en   = cmd.lookup || (cmd.scan && issue);
  assign rd_addr = cmd.lookup ? word_addr : scan_idx[ADDR_W-1:0];

  // words never written read as free
  assign word      = rd_data & {pfba_pkg::WORD_W{rd_mask}};
  assign word_full = (word == pfba_pkg::FULL_WORD);
  assign free_pos  = lowest_zero(word);

  assign status.scan_needed = (req_q.mode == pfba_pkg::MODE_ALLOC) &&
                              (req_q.page_frame == '0) && (limit != '0);
  assign status.word_needed = stored && (((req_q.mode == pfba_pkg::MODE_FREE) &&
                              (req_q.page_frame != '0)) ||
                              (req_q.mode == pfba_pkg::MODE_TEST));
  assign status.found       = chk_valid && !word_full;
  assign status.scan_end    = chk_valid && word_full &&
                              ({1'b0, chk_idx} == (limit - 8'd1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = word_addr;
    wr_data = word & ~(pfba_pkg::WORD_W'(1) << bit_pos);
    if (cmd.update && (req_q.mode == pfba_pkg::MODE_FREE)) begin
      wr_en = 1'b1;
    end else if (cmd.scan && status.found) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx[ADDR_W-1:0];
      wr_data = word | (pfba_pkg::WORD_W'(1) << free_pos);
    end
  end

  pfba_ram #(
    .WIDTH(pfba_pkg::WORD_W),
    .DEPTH(STORE_WORDS)
  ) u_bitmap (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= pfba_pkg::WORDS_RST_VAL;
      valid        <= '0;
      chk_valid    <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        words_in_use <= cfg_data;
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.init) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan) begin
        chk_valid <= issue;
      end
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= request;
    end
    if (rd_en) begin
      rd_mask <= valid[rd_addr];
    end
    if (cmd.init) begin
      scan_idx <= '0;
      found_q  <= 1'b0;
      inuse_q  <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) begin
        scan_idx <= scan_idx + 8'd1;
      end
      chk_idx <= scan_idx[pfba_pkg::WORD_IDX_W-1:0];
      if (status.found) begin
        found_q     <= 1'b1;
        found_frame <= {chk_idx, free_pos};
      end
    end
    if (cmd.update && (req_q.mode == pfba_pkg::MODE_TEST)) begin
      inuse_q <= word[bit_pos];
    end
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  always_comb begin
    res_next = '0;
    case (req_q.mode)
      pfba_pkg::MODE_ALLOC: begin
        if (req_q.page_frame != '0) begin
          res_next.entry_frame = req_q.page_frame;
        end else if (found_q) begin
          res_next.entry_frame   = found_frame;
          res_next.entry_present = 1'b1;
          res_next.entry_rw      = req_q.writable;
          res_next.entry_user    = ~req_q.kernel_only;
          res_next.entry_changed = 1'b1;
        end else begin
          res_next.no_free_frame = 1'b1;
        end
      end
      pfba_pkg::MODE_FREE: begin
        res_next.entry_changed = (req_q.page_frame != '0);
      end
      pfba_pkg::MODE_TEST: begin
        res_next.entry_frame  = req_q.page_frame;
        res_next.frame_in_use = inuse_q;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/page_frame_bitmap_allocator_top.sv
// Top level: first-fit page frame bitmap allocator, controller plus datapath.
// Allocate scans one bitmap word per cycle until the first word with a free frame
// or the word limit; free of a stored nonzero frame and test of a stored frame
// each look up one bitmap word, other requests go straight to the result.
// One item at a time, next accepted in the result cycle; results cannot be stalled.
// Reset: bitmap reads all free via per-word valid flags, words_in_use back to 128.
`default_nettype none
module page_frame_bitmap_allocator_top #(
  parameter int FRAME_COUNT = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire pfba_pkg::req_t             request,
  output logic                            done,
  output pfba_pkg::res_t                  result,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [pfba_pkg::CNT_W-1:0] cfg_data
);

  localparam int STORE_WORDS = (FRAME_COUNT / 32 < pfba_pkg::BITMAP_DEPTH) ?
                               FRAME_COUNT / 32 : pfba_pkg::BITMAP_DEPTH;

  pfba_pkg::ctrl_cmd_t    cmd;
  pfba_pkg::ctrl_status_t status;

  pfba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  pfba_datapath #(
    .STORE_WORDS(STORE_WORDS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .request  (request),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_alloc_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.entry_present) |-> (result.entry_changed && !result.no_free_frame))
    else $error("fresh allocation result inconsistent");

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for the page frame bitmap allocator: directed table, random phases, live predictor.
module tb;

  localparam int MAP_FRAMES   = 4096;
  localparam int RUN_LIMIT    = 1000000;
  localparam int STORED_WORDS = (MAP_FRAMES / pfba_pkg::WORD_W < pfba_pkg::BITMAP_DEPTH) ?
                                MAP_FRAMES / pfba_pkg::WORD_W : pfba_pkg::BITMAP_DEPTH;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 115;

  typedef struct {
    bit              is_cfg;
    int              reps;
    pfba_pkg::req_t  req;
    bit              pinned;
    pfba_pkg::res_t  want;
  } step_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  pfba_pkg::req_t             request = '0;
  logic                       done;
  pfba_pkg::res_t             result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [pfba_pkg::CNT_W-1:0] cfg_data = '0;

  // sideband travelling with each item: result typed in by hand, if any
  logic                       pin_known = 1'b0;
  pfba_pkg::res_t             pin_res = '0;

  logic [pfba_pkg::WORD_W-1:0] used_frames [pfba_pkg::BITMAP_DEPTH];
  int unsigned                 search_words;
  pfba_pkg::res_t              pending_entries [$];
  pfba_pkg::res_t              predicted;
  pfba_pkg::res_t              oldest;
  int                          fault_count = 0;
  int                          cycle_count = 0;
  int                          gap_pct = 6;
  step_t                       plan [24];
  logic [pfba_pkg::CNT_W-1:0]  phase_words [NUM_PHASES];
  int                          phase_alloc [NUM_PHASES];

  page_frame_bitmap_allocator_top #(.FRAME_COUNT(MAP_FRAMES)) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report(input string what, input int got, input int want);
    if (fault_count < 100) begin
      $display("ERROR t=%0t %s: got %0d, want %0d", $time, what, got, want);
    end
    fault_count++;
  endtask

  task automatic resolve_request(input pfba_pkg::req_t r, output pfba_pkg::res_t o);
    int          limit;
    bit          hit;
    bit          stored;
    int unsigned w_idx;
    int unsigned b_idx;
    o = '0;
    w_idx  = r.page_frame >> pfba_pkg::BIT_IDX_W;
    b_idx  = r.page_frame[pfba_pkg::BIT_IDX_W-1:0];
    stored = w_idx < STORED_WORDS;
    case (r.mode)
      pfba_pkg::MODE_ALLOC: begin
        o.entry_frame = r.page_frame;
        if (r.page_frame == '0) begin
          limit = (search_words > STORED_WORDS) ? STORED_WORDS : search_words;
          hit = 1'b0;
          for (int i = 0; i < limit && !hit; i++) begin
            for (int j = 0; j < pfba_pkg::WORD_W && !hit; j++) begin
              if (!used_frames[i][j]) begin
                used_frames[i][j] = 1'b1;
                o.entry_frame = pfba_pkg::FRAME_W'(i * pfba_pkg::WORD_W + j);
                hit = 1'b1;
              end
            end
          end
          if (hit) begin
            o.entry_present = 1'b1;
            o.entry_rw      = r.writable;
            o.entry_user    = ~r.kernel_only;
            o.entry_changed = 1'b1;
          end else begin
            o.no_free_frame = 1'b1;
          end
        end
      end
      pfba_pkg::MODE_FREE: begin
        if (r.page_frame != '0) begin
          if (stored) begin
            used_frames[w_idx][b_idx] = 1'b0;
          end
          o.entry_changed = 1'b1;
        end
      end
      pfba_pkg::MODE_TEST: begin
        o.entry_frame = r.page_frame;
        if (stored) begin
          o.frame_in_use = used_frames[w_idx][b_idx];
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_entry(input pfba_pkg::res_t got, input pfba_pkg::res_t want);
    if (got.entry_frame !== want.entry_frame)
      report("entry_frame", got.entry_frame, want.entry_frame);
    if (got.entry_present !== want.entry_present)
      report("entry_present", got.entry_present, want.entry_present);
    if (got.entry_rw !== want.entry_rw)
      report("entry_rw", got.entry_rw, want.entry_rw);
    if (got.entry_user !== want.entry_user)
      report("entry_user", got.entry_user, want.entry_user);
    if (got.entry_changed !== want.entry_changed)
      report("entry_changed", got.entry_changed, want.entry_changed);
    if (got.no_free_frame !== want.no_free_frame)
      report("no_free_frame", got.no_free_frame, want.no_free_frame);
    if (got.frame_in_use !== want.frame_in_use)
      report("frame_in_use", got.frame_in_use, want.frame_in_use);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (used_frames[w]) used_frames[w] = '0;
      search_words = pfba_pkg::WORDS_RST_VAL;
      pending_entries.delete();
    end else begin
      if (done) begin
        if (pending_entries.size() == 0) begin
          report("result with nothing outstanding", result.entry_frame, 0);
        end else begin
          oldest = pending_entries.pop_front();
          compare_entry(result, oldest);
        end
      end
      if (start && !busy) begin
        resolve_request(request, predicted);
        pending_entries.push_back(pin_known ? pin_res : predicted);
      end
      if (cfg_valid && cfg_ready) search_words = cfg_data;
    end
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("page_frame_bitmap_allocator_top: mismatch");
      $finish;
    end
  end

  function automatic step_t row(bit is_cfg, int reps, logic [1:0] m,
                                logic [pfba_pkg::FRAME_W-1:0] f, bit k, bit w, bit pin,
                                logic [$bits(pfba_pkg::res_t)-1:0] want);
    step_t s;
    s.is_cfg = is_cfg;
    s.reps   = reps;
    s.req    = pfba_pkg::req_t'({m, f, k, w});
    s.pinned = pin;
    s.want   = pfba_pkg::res_t'(want);
    return s;
  endfunction

  function automatic pfba_pkg::req_t random_req(int alloc_pct);
    pfba_pkg::req_t r;
    int             pick;
    r.kernel_only = 1'($urandom_range(1));
    r.writable    = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      r.mode = pfba_pkg::MODE_ALLOC;
      r.page_frame = ($urandom_range(9) == 0) ? pfba_pkg::FRAME_W'($urandom) : '0;
    end else begin
      r.mode = $urandom_range(1) ? pfba_pkg::MODE_FREE : pfba_pkg::MODE_TEST;
      r.page_frame = ($urandom_range(3) == 0) ? pfba_pkg::FRAME_W'($urandom)
                                               : pfba_pkg::FRAME_W'($urandom_range(0, 191));
      if ($urandom_range(29) == 0) r.mode = MODE_NONE;
    end
    return r;
  endfunction

  task automatic send_item(input pfba_pkg::req_t r, input bit pin, input pfba_pkg::res_t want);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start     <= 1'b1;
    request   <= r;
    pin_known <= pin;
    pin_res   <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_entries.size() != 0) @(posedge clk);
  endtask

  task automatic set_search_words(input logic [pfba_pkg::CNT_W-1:0] v);
    drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    // want = {entry_frame, present, rw, user, changed, no_free, in_use}
    // config rows carry the register value in the frame column
    plan = '{
      row(0, 1, pfba_pkg::MODE_TEST,  12'd0,    0, 0, 1, {12'd0,    6'b000000}),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd0,    0, 1, 1, {12'd0,    6'b111100}),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd0,    1, 0, 1, {12'd1,    6'b100100}),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd4095, 1, 1, 1, {12'd4095, 6'b000000}),
      row(0, 1, pfba_pkg::MODE_TEST,  12'd1,    0, 0, 1, {12'd1,    6'b000001}),
      row(0, 1, pfba_pkg::MODE_TEST,  12'd4095, 1, 1, 1, {12'd4095, 6'b000000}),
      row(0, 1, pfba_pkg::MODE_FREE,  12'd1,    0, 0, 1, {12'd0,    6'b000100}),
      row(0, 1, pfba_pkg::MODE_FREE,  12'd0,    1, 1, 1, {12'd0,    6'b000000}),
      row(0, 1, pfba_pkg::MODE_TEST,  12'd0,    0, 0, 1, {12'd0,    6'b000001}),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd0,    0, 0, 1, {12'd1,    6'b101100}),
      row(0, 1, MODE_NONE,            12'd4095, 1, 1, 1, {12'd0,    6'b000000}),
      row(0, 1, pfba_pkg::MODE_FREE,  12'd4095, 1, 1, 1, {12'd0,    6'b000100}),
      row(1, 0, pfba_pkg::MODE_ALLOC, 12'd0,    0, 0, 0, '0),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd0,    1, 1, 1, {12'd0,    6'b000010}),
      row(1, 0, pfba_pkg::MODE_ALLOC, 12'd1,    0, 0, 0, '0),
      row(0, 30, pfba_pkg::MODE_ALLOC, 12'd0,   0, 1, 0, '0),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd0,    0, 1, 1, {12'd0,    6'b000010}),
      row(0, 1, pfba_pkg::MODE_TEST,  12'd31,   0, 0, 1, {12'd31,   6'b000001}),
      row(1, 0, pfba_pkg::MODE_ALLOC, 12'd255,  0, 0, 0, '0),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd0,    1, 1, 1, {12'd32,   6'b110100}),
      row(0, 1, pfba_pkg::MODE_FREE,  12'd2048, 0, 1, 1, {12'd0,    6'b000100}),
      row(0, 1, pfba_pkg::MODE_TEST,  12'd2730, 1, 0, 0, '0),
      row(1, 0, pfba_pkg::MODE_ALLOC, 12'd128,  0, 0, 0, '0),
      row(0, 1, pfba_pkg::MODE_ALLOC, 12'd1365, 0, 1, 1, {12'd1365, 6'b000000})
    };
    phase_words = '{8'd128, 8'd2, 8'd0, 8'd255, 8'd1, 8'd5, 8'd128, 8'd3,
                    pfba_pkg::CNT_W'($urandom_range(1, 127))};
    phase_alloc = '{50, 70, 45, 60, 80, 55, 40, 75, 50};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        set_search_words(plan[n].req.page_frame[pfba_pkg::CNT_W-1:0]);
      end else begin
        repeat (plan[n].reps) send_item(plan[n].req, plan[n].pinned, plan[n].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      gap_pct = (p < 3) ? 6 : (p < 6) ? 66 : 0;
      set_search_words(phase_words[p]);
      repeat (PHASE_ITEMS) send_item(random_req(phase_alloc[p]), 1'b0, '0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("page_frame_bitmap_allocator_top: match");
    end else begin
      $display("page_frame_bitmap_allocator_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pfba_pkg.sv
hw/rtl/pfba_ram.sv
hw/rtl/pfba_ctrl.sv
hw/rtl/pfba_datapath.sv
hw/rtl/page_frame_bitmap_allocator_top.sv
sim/tb.sv
